>>> hw/rtl/amrr_pkg.sv
// amrr_pkg: item function codes, register map and constants of the AMRR rate controller.
// No dependencies; imported by amrr_rate_control.
package amrr_pkg;

    // item function codes carried on s_tuser
    localparam logic [2:0] FUNC_LOAD   = 3'd0;
    localparam logic [2:0] FUNC_RESET  = 3'd1;
    localparam logic [2:0] FUNC_REPORT = 3'd2;
    localparam logic [2:0] FUNC_TICK   = 3'd3;
    localparam logic [2:0] FUNC_CHOOSE = 3'd4;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_TX_CHAINS  = 3'd0;
    localparam logic [2:0] REG_MIN_THRESH = 3'd1;
    localparam logic [2:0] REG_MAX_THRESH = 3'd2;
    localparam logic [2:0] REG_INTERVAL   = 3'd3;
    localparam logic [2:0] REG_HT_MODE    = 3'd4;
    localparam logic [2:0] REG_RATE_COUNT = 3'd5;

    // register reset values
    localparam logic [2:0]  TX_CHAINS_RST  = 3'd1;
    localparam logic [7:0]  MIN_THRESH_RST = 8'd1;
    localparam logic [7:0]  MAX_THRESH_RST = 8'd15;
    localparam logic [15:0] INTERVAL_RST   = 16'd100;
    localparam logic [4:0]  RATE_COUNT_RST = 5'd1;

    // port widths
    localparam int FUNC_W      = 3;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_ADDR_W  = 5;
    localparam int CFG_DATA_W  = 32;

    // evaluation and scan constants
    localparam logic [15:0] EVAL_MIN_FRAMES   = 16'd10;
    localparam logic [6:0]  LEGACY_SCAN_LIMIT = 7'd72;
    localparam logic [6:0]  HT_SCAN_LIMIT     = 7'd4;
    localparam logic [7:0]  MCS_FLAG          = 8'h80;

endpackage

>>> hw/rtl/amrr_ram.sv
// amrr_ram: generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies; holds the rate table of amrr_rate_control.
module amrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        // hold the last read word while no read is issued
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/amrr_rate_control.sv
// amrr_rate_control: AMRR transmit rate selection for one link, top level.
// Depends on amrr_pkg (codes, constants) and amrr_ram (rate table storage).
//
// Usage:
//  Items arrive as beats on the s_ channel: s_tuser carries the function code
//  (load table entry, reset link, tx report, tick, choose rate), s_tdata the
//  operands. Every accepted beat yields exactly one result beat on the m_
//  channel: current rate index, rate code, a moved-rate flag and an
//  evaluated flag. Registers sit behind the APB port; write them only while
//  the block is idle.
//  Sequencing: one item at a time. A load, report, tick or choose without
//  evaluation reads the current table entry (ST_CODE_RD, ST_CODE_WAIT) and
//  then presents the result; a choose that evaluates first does one extra
//  table read for the next rate (ST_EVAL_RD, ST_EVAL). A link reset walks
//  the table downward, one read of the table RAM plus a compare per entry
//  visited (ST_SCAN_RD, ST_SCAN_CHK), then presents the entry it stops at.
//  Reset: rst_n clears the link state and restores register defaults; the
//  rate table holds garbage until loaded and must be loaded before use.
//  Stall: a result holds in the output register while m_tready is low; the
//  next item is accepted meanwhile and waits in its last step until the
//  output register frees.
module amrr_rate_control #(
    parameter int MAX_RATES = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input item stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [3:0] entry_index, [11:4] entry_value, [19:12] frames_sent,
    // [27:20] retries_seen, [31:28] zero
    input  logic [amrr_pkg::IN_TDATA_W-1:0]  s_tdata,
    // [2:0] func
    input  logic [amrr_pkg::FUNC_W-1:0]      s_tuser,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [3:0] rate_pos, [11:4] tx_rate_code, [12] rate_changed,
    // [13] evaluated, [15:14] zero
    output logic [amrr_pkg::OUT_TDATA_W-1:0] m_tdata,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [amrr_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [amrr_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [amrr_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);

    import amrr_pkg::*;

    localparam int IDX_W = $clog2(MAX_RATES);
    localparam logic [4:0] MAX_RATES_W = 5'(MAX_RATES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EVAL_RD,
        ST_EVAL,
        ST_CODE_RD,
        ST_CODE_WAIT
    } state_t;

    // configuration registers
    logic [2:0]  tx_chains_reg;
    logic [7:0]  min_thresh_reg;
    logic [7:0]  max_thresh_reg;
    logic [15:0] interval_reg;
    logic        ht_mode_reg;
    logic [4:0]  rate_count_reg;

    // link state
    state_t           state_reg;
    logic [IDX_W-1:0] cur_idx_reg;
    logic [IDX_W-1:0] before_idx_reg;
    logic [7:0]       success_run_reg;
    logic [7:0]       thresh_reg;
    logic             recovering_reg;
    logic [15:0]      frame_total_reg;
    logic [15:0]      retry_total_reg;
    logic [15:0]      elapsed_reg;
    logic [2:0]       func_reg;
    logic             evald_reg;

    // output register
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    // ------------------------------------------------------------------
    // APB register file: pready is always high, writes complete on access
    // ------------------------------------------------------------------
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_chains_reg  <= TX_CHAINS_RST;
            min_thresh_reg <= MIN_THRESH_RST;
            max_thresh_reg <= MAX_THRESH_RST;
            interval_reg   <= INTERVAL_RST;
            ht_mode_reg    <= 1'b0;
            rate_count_reg <= RATE_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_TX_CHAINS:  tx_chains_reg  <= pwdata[2:0];
                REG_MIN_THRESH: min_thresh_reg <= pwdata[7:0];
                REG_MAX_THRESH: max_thresh_reg <= pwdata[7:0];
                REG_INTERVAL:   interval_reg   <= pwdata[15:0];
                REG_HT_MODE:    ht_mode_reg    <= pwdata[0];
                REG_RATE_COUNT: rate_count_reg <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (paddr[4:2])
            REG_TX_CHAINS:  prdata = {29'd0, tx_chains_reg};
            REG_MIN_THRESH: prdata = {24'd0, min_thresh_reg};
            REG_MAX_THRESH: prdata = {24'd0, max_thresh_reg};
            REG_INTERVAL:   prdata = {16'd0, interval_reg};
            REG_HT_MODE:    prdata = {31'd0, ht_mode_reg};
            REG_RATE_COUNT: prdata = {27'd0, rate_count_reg};
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input beat decode
    // ------------------------------------------------------------------
    logic [3:0] in_pos;
    logic [7:0] in_value;
    logic [7:0] in_frames;
    logic [7:0] in_retries;
    logic       in_accept;

    assign in_pos     = s_tdata[3:0];
    assign in_value   = s_tdata[11:4];
    assign in_frames  = s_tdata[19:12];
    assign in_retries = s_tdata[27:20];
    assign s_tready   = (state_reg == ST_IDLE);
    assign in_accept  = s_tvalid && s_tready;

    // usable table length: zero acts as one, clip at the table depth
    logic [4:0]       valid_count;
    logic [IDX_W-1:0] last_idx;
    always_comb
    begin
        if (rate_count_reg == 5'd0)
            valid_count = 5'd1;
        else if (rate_count_reg > MAX_RATES_W)
            valid_count = MAX_RATES_W;
        else
            valid_count = rate_count_reg;
    end
    assign last_idx = IDX_W'(valid_count - 5'd1);

    // ------------------------------------------------------------------
    // Rate table RAM: written by load beats, read by scan, eval and result
    // ------------------------------------------------------------------
    logic             ram_wr_en;
    logic             ram_rd_en;
    logic [IDX_W-1:0] ram_rd_addr;
    logic [7:0]       ram_rd_data;

    assign ram_wr_en = in_accept && (s_tuser == FUNC_LOAD) && ({1'b0, in_pos} < MAX_RATES_W);
    assign ram_rd_en = (state_reg == ST_SCAN_RD) || (state_reg == ST_EVAL_RD) ||
                       (state_reg == ST_CODE_RD);
    assign ram_rd_addr = (state_reg == ST_EVAL_RD) ? (cur_idx_reg + IDX_W'(1)) : cur_idx_reg;

    amrr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_RATES)
    ) u_rate_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (in_pos[IDX_W-1:0]),
        .wr_data (in_value),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Saturating counter updates for report and tick beats
    // ------------------------------------------------------------------
    logic [16:0] frame_sum;
    logic [16:0] retry_sum;
    logic [15:0] frame_sat;
    logic [15:0] retry_sat;
    logic [15:0] elapsed_sat;

    assign frame_sum   = {1'b0, frame_total_reg} + {9'd0, in_frames};
    assign retry_sum   = {1'b0, retry_total_reg} + {9'd0, in_retries};
    assign frame_sat   = frame_sum[16] ? 16'hFFFF : frame_sum[15:0];
    assign retry_sat   = retry_sum[16] ? 16'hFFFF : retry_sum[15:0];
    assign elapsed_sat = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;

    logic eval_due;
    assign eval_due = (frame_total_reg > EVAL_MIN_FRAMES) && (elapsed_reg > interval_reg);

    // ------------------------------------------------------------------
    // Evaluation: success when retries < frames/10, i.e. 10*(retries+1) <= frames;
    // failure when retries > frames/3, i.e. 3*retries > frames
    // ------------------------------------------------------------------
    logic [16:0]      retry_p1;
    logic [20:0]      retry_x10;
    logic [17:0]      retry_x3;
    logic             success_hit;
    logic             fail_hit;
    logic [7:0]       sr_inc;
    logic [4:0]       cur_p1;
    logic             step_up;
    logic [8:0]       thresh_dbl;
    logic [7:0]       thresh_fail;
    logic [IDX_W-1:0] cur_idx_next;
    logic [7:0]       success_run_next;
    logic [7:0]       thresh_next;
    logic             recovering_next;

    assign retry_p1    = {1'b0, retry_total_reg} + 17'd1;
    assign retry_x10   = {1'b0, retry_p1, 3'b000} + {3'b000, retry_p1, 1'b0};
    assign retry_x3    = {1'b0, retry_total_reg, 1'b0} + {2'b00, retry_total_reg};
    assign success_hit = retry_x10 <= {5'd0, frame_total_reg};
    assign fail_hit    = retry_x3 > {2'b00, frame_total_reg};
    assign sr_inc      = (success_run_reg == 8'hFF) ? success_run_reg : success_run_reg + 8'd1;
    assign cur_p1      = 5'(cur_idx_reg) + 5'd1;
    // in HT the next MCS must stay below chains*8; ram_rd_data holds entry cur+1 here
    assign step_up     = (sr_inc >= thresh_reg) && (cur_p1 < valid_count) &&
                         (!ht_mode_reg || (ram_rd_data[6:0] < {1'b0, tx_chains_reg, 3'b000}));
    assign thresh_dbl  = {thresh_reg, 1'b0};
    assign thresh_fail = recovering_reg ?
                         ((thresh_dbl > {1'b0, max_thresh_reg}) ? max_thresh_reg : thresh_dbl[7:0]) :
                         min_thresh_reg;

    always_comb
    begin
        cur_idx_next     = cur_idx_reg;
        success_run_next = success_run_reg;
        thresh_next      = thresh_reg;
        recovering_next  = recovering_reg;
        if (success_hit)
        begin
            if (step_up)
            begin
                recovering_next  = 1'b1;
                success_run_next = 8'd0;
                cur_idx_next     = cur_idx_reg + IDX_W'(1);
            end
            else
            begin
                recovering_next  = 1'b0;
                success_run_next = sr_inc;
            end
        end
        else if (fail_hit)
        begin
            success_run_next = 8'd0;
            recovering_next  = 1'b0;
            if (cur_idx_reg != '0)
            begin
                thresh_next  = thresh_fail;
                cur_idx_next = cur_idx_reg - IDX_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic [6:0] scan_limit;
    logic       out_free;
    logic       out_load;
    logic [7:0] rate_code;

    assign scan_limit = ht_mode_reg ? HT_SCAN_LIMIT : LEGACY_SCAN_LIMIT;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign out_load   = (state_reg == ST_CODE_WAIT) && out_free;
    assign rate_code  = ht_mode_reg ? (ram_rd_data | MCS_FLAG) : {1'b0, ram_rd_data[6:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cur_idx_reg     <= '0;
            before_idx_reg  <= '0;
            success_run_reg <= 8'd0;
            thresh_reg      <= MIN_THRESH_RST;
            recovering_reg  <= 1'b0;
            frame_total_reg <= 16'd0;
            retry_total_reg <= 16'd0;
            elapsed_reg     <= 16'd0;
            func_reg        <= FUNC_LOAD;
            evald_reg       <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            m_tdata_reg     <= '0;
        end
        else
        begin
            // drop the result once the sink takes it, unless a new one loads
            if (m_tready && !out_load)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        func_reg       <= s_tuser;
                        before_idx_reg <= cur_idx_reg;
                        evald_reg      <= 1'b0;
                        state_reg      <= ST_CODE_RD;
                        case (s_tuser)
                            FUNC_RESET:
                            begin
                                // start the downward scan at the last valid entry
                                cur_idx_reg     <= last_idx;
                                success_run_reg <= 8'd0;
                                recovering_reg  <= 1'b0;
                                frame_total_reg <= 16'd0;
                                retry_total_reg <= 16'd0;
                                elapsed_reg     <= 16'd0;
                                thresh_reg      <= min_thresh_reg;
                                state_reg       <= ST_SCAN_RD;
                            end
                            FUNC_REPORT:
                            begin
                                frame_total_reg <= frame_sat;
                                retry_total_reg <= retry_sat;
                            end
                            FUNC_TICK:
                            begin
                                elapsed_reg <= elapsed_sat;
                            end
                            FUNC_CHOOSE:
                            begin
                                if (eval_due)
                                begin
                                    evald_reg <= 1'b1;
                                    state_reg <= ST_EVAL_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                ST_SCAN_RD:
                begin
                    state_reg <= ST_SCAN_CHK;
                end

                ST_SCAN_CHK:
                begin
                    // step down while above entry 0 and the rate exceeds the limit;
                    // on stop the read word already is the current entry
                    if ((cur_idx_reg != '0) && (ram_rd_data[6:0] > scan_limit))
                    begin
                        cur_idx_reg <= cur_idx_reg - IDX_W'(1);
                        state_reg   <= ST_SCAN_RD;
                    end
                    else
                    begin
                        state_reg <= ST_CODE_WAIT;
                    end
                end

                ST_EVAL_RD:
                begin
                    state_reg <= ST_EVAL;
                end

                ST_EVAL:
                begin
                    cur_idx_reg     <= cur_idx_next;
                    success_run_reg <= success_run_next;
                    thresh_reg      <= thresh_next;
                    recovering_reg  <= recovering_next;
                    frame_total_reg <= 16'd0;
                    retry_total_reg <= 16'd0;
                    elapsed_reg     <= 16'd0;
                    state_reg       <= ST_CODE_RD;
                end

                ST_CODE_RD:
                begin
                    state_reg <= ST_CODE_WAIT;
                end

                ST_CODE_WAIT:
                begin
                    // hold the read word until the output register frees
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {2'b00, evald_reg, (cur_idx_reg != before_idx_reg),
                                         rate_code, 4'(cur_idx_reg)};
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_eval_only_on_choose: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CODE_WAIT && out_free) |=> (!m_tdata_reg[13] || func_reg == FUNC_CHOOSE))
        else $error("evaluated flag set on a non-choose item");

    a_reset_clears_counters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_tuser == FUNC_RESET) |=>
        (frame_total_reg == 16'd0 && retry_total_reg == 16'd0 && elapsed_reg == 16'd0 &&
         state_reg == ST_SCAN_RD))
        else $error("link reset did not clear counters or start the scan");

    a_scan_stops_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN_CHK && cur_idx_reg == '0) |=> (state_reg == ST_CODE_WAIT))
        else $error("table scan went below entry zero");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CODE_WAIT && out_free) |=> (m_tvalid_reg && state_reg == ST_IDLE))
        else $error("result not presented after the final table read");

endmodule

>>> bench/amrr_rate_control_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for amrr_rate_control: random and directed item beats, APB setup.
// Depends on amrr_pkg and the amrr_rate_control RTL; a local link tracker predicts results.

module amrr_rate_control_tb;
    import amrr_pkg::*;

    localparam int NUM_RATES        = 16;
    localparam int MIN_EVAL_FRAMES  = 10;
    localparam int LEGACY_LIMIT     = 72;
    localparam int HT_LIMIT         = 4;
    localparam int MAX_REPORTS      = 10;
    localparam int SETTLE_CYCLES    = 40;    // outlasts the longest link reset scan
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT      = 2000;  // cycles without any accepted beat

    // function codes the block does not define; they must leave the link alone
    localparam logic [2:0] FUNC_SPARE_A = 3'd5;
    localparam logic [2:0] FUNC_SPARE_B = 3'd6;
    localparam logic [2:0] FUNC_SPARE_C = 3'd7;

    typedef struct packed {
        logic       evaluated;
        logic       rate_changed;
        logic [7:0] rate_code;
        logic [3:0] rate_pos;
    } rate_result_t;

    typedef enum int {LINK_GOOD, LINK_POOR, LINK_FLAT} link_quality_t;

    // Tracks the link the way the block should: rate table, success run,
    // threshold, recovery flag and the three saturating counters.
    class amrr_link_tracker;
        bit [7:0]     rate_tbl [NUM_RATES];
        bit [3:0]     cur_idx;
        bit [7:0]     success_cnt;
        bit [7:0]     cur_thresh;
        bit           in_recovery;
        bit [15:0]    frame_sum;
        bit [15:0]    retry_sum;
        bit [15:0]    tick_sum;
        bit [2:0]     chains;
        bit [7:0]     thresh_min;
        bit [7:0]     thresh_max;
        bit [15:0]    interval;
        bit           ht;
        bit [4:0]     rate_cnt;
        rate_result_t rates_due [$];
        int           mismatches;
        int           results_seen;
        int           evals_seen;
        int           moves_seen;

        function new();
            foreach (rate_tbl[i])
                rate_tbl[i] = 8'h00;
            chains      = TX_CHAINS_RST;
            thresh_min  = MIN_THRESH_RST;
            thresh_max  = MAX_THRESH_RST;
            interval    = INTERVAL_RST;
            ht          = 1'b0;
            rate_cnt    = RATE_COUNT_RST;
            cur_idx     = '0;
            success_cnt = '0;
            cur_thresh  = MIN_THRESH_RST;
            in_recovery = 1'b0;
            frame_sum   = '0;
            retry_sum   = '0;
            tick_sum    = '0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_TX_CHAINS:  chains     = val[2:0];
                REG_MIN_THRESH: thresh_min = val[7:0];
                REG_MAX_THRESH: thresh_max = val[7:0];
                REG_INTERVAL:   interval   = val[15:0];
                REG_HT_MODE:    ht         = val[0];
                REG_RATE_COUNT: rate_cnt   = val[4:0];
                default: ;
            endcase
        endfunction

        function int usable_rates();
            int n;
            n = int'(rate_cnt);
            if (n < 1)
                n = 1;
            if (n > NUM_RATES)
                n = NUM_RATES;
            return n;
        endfunction

        function void reset_link();
            int i;
            int lim;
            lim = ht ? HT_LIMIT : LEGACY_LIMIT;
            i = usable_rates() - 1;
            while (i > 0 && int'(rate_tbl[i][6:0]) > lim)
                i--;
            cur_idx     = 4'(i);
            success_cnt = '0;
            in_recovery = 1'b0;
            frame_sum   = '0;
            retry_sum   = '0;
            cur_thresh  = thresh_min;
            tick_sum    = '0;
        endfunction

        function void evaluate();
            int idx;
            int ft;
            int rt;
            int dbl;
            idx = int'(cur_idx);
            ft  = int'(frame_sum);
            rt  = int'(retry_sum);
            if (rt < ft / 10)
            begin
                if (success_cnt != 8'hFF)
                    success_cnt++;
                if (success_cnt >= cur_thresh && idx + 1 < usable_rates() &&
                    (!ht || int'(rate_tbl[idx + 1][6:0]) < int'(chains) * 8))
                begin
                    in_recovery = 1'b1;
                    success_cnt = '0;
                    idx++;
                end
                else
                begin
                    in_recovery = 1'b0;
                end
            end
            else if (rt > ft / 3)
            begin
                success_cnt = '0;
                if (idx > 0)
                begin
                    if (in_recovery)
                    begin
                        dbl = int'(cur_thresh) * 2;
                        cur_thresh = (dbl > int'(thresh_max)) ? thresh_max : 8'(dbl);
                    end
                    else
                    begin
                        cur_thresh = thresh_min;
                    end
                    idx--;
                end
                in_recovery = 1'b0;
            end
            cur_idx   = 4'(idx);
            frame_sum = '0;
            retry_sum = '0;
            tick_sum  = '0;
        endfunction

        function void note_item(logic [2:0] func, logic [31:0] data);
            bit [3:0]     prev_idx;
            bit           evald;
            int           sum;
            rate_result_t want;
            prev_idx = cur_idx;
            evald    = 1'b0;
            case (func)
                FUNC_LOAD:
                    rate_tbl[data[3:0]] = data[11:4];
                FUNC_RESET:
                    reset_link();
                FUNC_REPORT:
                begin
                    sum = int'(frame_sum) + int'(data[19:12]);
                    frame_sum = (sum > 65535) ? 16'hFFFF : 16'(sum);
                    sum = int'(retry_sum) + int'(data[27:20]);
                    retry_sum = (sum > 65535) ? 16'hFFFF : 16'(sum);
                end
                FUNC_TICK:
                    if (tick_sum != 16'hFFFF)
                        tick_sum++;
                FUNC_CHOOSE:
                    if (int'(frame_sum) > MIN_EVAL_FRAMES && tick_sum > interval)
                    begin
                        evaluate();
                        evald = 1'b1;
                    end
                default: ;
            endcase
            want.rate_pos     = cur_idx;
            want.rate_code    = ht ? (rate_tbl[cur_idx] | 8'h80)
                                   : {1'b0, rate_tbl[cur_idx][6:0]};
            want.rate_changed = (cur_idx != prev_idx);
            want.evaluated    = evald;
            rates_due.push_back(want);
        endfunction

        function void check_result(logic [15:0] data);
            rate_result_t got;
            rate_result_t want;
            got.rate_pos     = data[3:0];
            got.rate_code    = data[11:4];
            got.rate_changed = data[12];
            got.evaluated    = data[13];
            results_seen++;
            if (rates_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR %0t: result beat idx %0d code %02h with no item outstanding",
                             $time, got.rate_pos, got.rate_code);
                return;
            end
            want = rates_due.pop_front();
            if (want.evaluated)
                evals_seen++;
            if (want.rate_changed)
                moves_seen++;
            if (got.rate_pos !== want.rate_pos || got.rate_code !== want.rate_code ||
                got.rate_changed !== want.rate_changed || got.evaluated !== want.evaluated)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR %0t: want idx %0d code %02h moved %0b eval %0b, got %0d %02h %0b %0b",
                             $time, want.rate_pos, want.rate_code, want.rate_changed,
                             want.evaluated, got.rate_pos, got.rate_code,
                             got.rate_changed, got.evaluated);
            end
        endfunction

        function int pending();
            return rates_due.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // [3:0] entry_index, [11:4] entry_value,
                                       // [19:12] frames_sent, [27:20] retries_seen
    logic [FUNC_W-1:0]      s_tuser;   // [2:0] func
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // [3:0] rate_pos, [11:4] tx_rate_code,
                                       // [12] rate_changed, [13] evaluated
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [CFG_ADDR_W-1:0]  paddr;
    logic [CFG_DATA_W-1:0]  pwdata;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    amrr_link_tracker tracker;
    bit               calm;           // no random idling on either side while set
    bit               long_hold_req;  // ask the result sink for one long hold-off
    int               items_sent;
    int               quiet_cycles;
    logic [7:0]       seed_rates [NUM_RATES];

    amrr_rate_control #(
        .MAX_RATES (NUM_RATES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Mostly short idle stretches, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 2);
        if (r < 92)
            return $urandom_range(3, 8);
        return $urandom_range(20, 80);
    endfunction

    // Sample both streams at the rising edge: the tracker learns each accepted
    // item beat and checks each accepted result beat. The same edge feeds the
    // watchdog, which gives up after a long stretch with no beat moving.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            tracker.check_result(m_tdata);
        if (s_tvalid && s_tready)
            tracker.note_item(s_tuser, s_tdata);
        if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("ERROR: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // Result sink: drive m_tready at the falling edge. Random stalls unless
    // calm; on request hold off for a long stretch so the block fills up
    // and pushes back on its input.
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                m_tready = 1'b1;
            end
            else if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else if (!calm && $urandom_range(0, 99) < 25)
            begin
                m_tready = 1'b0;
                stall_left = gap_len() - 1;
            end
            else
            begin
                m_tready = 1'b1;
            end
        end
    end

    // Offer one item beat and hold it until accepted. Valid stays high on
    // return so a following item goes out back to back; any pause lowers it.
    task automatic send_item(input logic [2:0] func, input logic [3:0] pos,
                             input logic [7:0] value, input logic [7:0] frames,
                             input logic [7:0] retries);
        if (!calm && $urandom_range(0, 99) < 35)
        begin
            s_tvalid = 1'b0;
            repeat (gap_len()) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = func;
        s_tdata  = {4'h0, retries, frames, value, pos};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        @(negedge clk);
    endtask

    // Stop sending and wait until every outstanding result has come back,
    // then let the block settle.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle; the register takes the value
    // at the edge where psel, penable, pwrite and pready are all high.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        tracker.set_reg(idx, val);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apply_setup(input logic [2:0] chains, input logic [7:0] thr_lo,
                               input logic [7:0] thr_hi, input logic [15:0] ival,
                               input logic ht, input logic [4:0] nrates);
        wait_drained();
        write_reg(REG_TX_CHAINS, 32'(chains));
        write_reg(REG_MIN_THRESH, 32'(thr_lo));
        write_reg(REG_MAX_THRESH, 32'(thr_hi));
        write_reg(REG_INTERVAL, 32'(ival));
        write_reg(REG_HT_MODE, 32'(ht));
        write_reg(REG_RATE_COUNT, 32'(nrates));
    endtask

    // One well-formed evaluation round: a report whose retry share lands in
    // the chosen band, enough ticks to pass an interval below 16, then a choose.
    task automatic eval_cycle(input link_quality_t quality);
        int frames;
        int retries;
        int ticks;
        frames = $urandom_range(11, 255);
        case (quality)
            LINK_GOOD: retries = $urandom_range(0, frames / 10 - 1);
            LINK_POOR: retries = $urandom_range(frames / 3 + 1, 255);
            default:   retries = $urandom_range(frames / 10, frames / 3);
        endcase
        send_item(FUNC_REPORT, 4'($urandom), 8'($urandom), 8'(frames), 8'(retries));
        // keep tick runs short when the interval is huge; no evaluation then
        if (tracker.interval < 16)
            ticks = int'(tracker.interval) + 1 + $urandom_range(0, 1);
        else
            ticks = $urandom_range(1, 4);
        repeat (ticks)
            send_item(FUNC_TICK, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        send_item(FUNC_CHOOSE, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        // a second choose right away finds cleared counters if the first one evaluated
        if ($urandom_range(0, 9) == 0)
            send_item(FUNC_CHOOSE, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Mostly evaluation rounds with random content; the rest is noise:
    // link resets, table reloads, stray reports and chooses, any func code.
    task automatic run_mixed(input int count);
        int target;
        int r;
        int q;
        target = items_sent + count;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 39) == 0)
                calm = !calm;
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                q = $urandom_range(0, 99);
                if (q < 50)
                    eval_cycle(LINK_GOOD);
                else if (q < 80)
                    eval_cycle(LINK_POOR);
                else
                    eval_cycle(LINK_FLAT);
            end
            else if (r < 78)
                send_item(FUNC_RESET, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            else if (r < 86)
                send_item(FUNC_LOAD, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            else if (r < 92)
                send_item(FUNC_REPORT, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            else if (r < 96)
                send_item(FUNC_CHOOSE, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            else
                send_item(3'($urandom_range(0, 7)), 4'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom));
        end
        calm = 1'b0;
    endtask

    initial
    begin
        tracker       = new();
        calm          = 1'b0;
        long_hold_req = 1'b0;
        items_sent    = 0;
        quiet_cycles  = 0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        // rate bytes: extremes 0x00 and 0xFF, low seven bits on both sides of
        // the legacy and HT scan limits, MCS flag set on some
        seed_rates = '{8'h00, 8'h04, 8'h8B, 8'h16, 8'h0C, 8'h12, 8'h18, 8'h24,
                       8'h30, 8'h48, 8'h49, 8'h60, 8'h6C, 8'h7F, 8'hC8, 8'hFF};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: fill the whole table first, entry 0 leading, so no
        // result ever reads an entry that was never loaded.
        calm = 1'b1;
        for (int i = 0; i < NUM_RATES; i++)
            send_item(FUNC_LOAD, 4'(i), seed_rates[i], 8'h00, 8'h00);
        // undefined func codes change nothing
        send_item(FUNC_SPARE_A, 4'hF, 8'hFF, 8'hFF, 8'hFF);
        send_item(FUNC_SPARE_B, 4'h0, 8'h00, 8'h00, 8'h00);
        send_item(FUNC_SPARE_C, 4'hA, 8'h55, 8'hAA, 8'h55);
        send_item(FUNC_RESET, 4'h0, 8'h00, 8'h00, 8'h00);
        send_item(FUNC_REPORT, 4'h0, 8'h00, 8'hFF, 8'hFF);
        send_item(FUNC_REPORT, 4'hF, 8'hFF, 8'h00, 8'h00);
        send_item(FUNC_TICK, 4'h0, 8'h00, 8'h00, 8'h00);
        // interval still at its reset value: no evaluation yet
        send_item(FUNC_CHOOSE, 4'h0, 8'h00, 8'h00, 8'h00);
        calm = 1'b0;

        // Legacy, full table, zero interval: frequent evaluations. Midway,
        // hold the result side off while the sender keeps offering beats.
        apply_setup(3'd1, 8'd1, 8'd15, 16'd0, 1'b0, 5'd16);
        send_item(FUNC_RESET, 4'h0, 8'h00, 8'h00, 8'h00);
        run_mixed(80);
        calm = 1'b1;
        long_hold_req = 1'b1;
        repeat (12)
            eval_cycle(LINK_GOOD);
        calm = 1'b0;
        run_mixed(80);

        // HT with one chain: the MCS cap blocks most steps up
        apply_setup(3'd1, 8'd2, 8'd255, 16'd2, 1'b1, 5'd16);
        send_item(FUNC_RESET, 4'h0, 8'h00, 8'h00, 8'h00);
        run_mixed(90);

        // HT with four chains, short table, doubling capped low
        apply_setup(3'd4, 8'd3, 8'd8, 16'd1, 1'b1, 5'd10);
        send_item(FUNC_RESET, 4'h0, 8'h00, 8'h00, 8'h00);
        run_mixed(90);

        // zero thresholds, rate count above the table size
        apply_setup(3'd7, 8'd0, 8'd0, 16'd3, 1'b0, 5'd31);
        send_item(FUNC_RESET, 4'h0, 8'h00, 8'h00, 8'h00);
        run_mixed(90);

        // Rate count zero acts as one rate: no step up is possible, so an
        // unbroken success run climbs past the threshold of 16.
        apply_setup(3'd2, 8'd16, 8'd255, 16'd0, 1'b0, 5'd0);
        send_item(FUNC_RESET, 4'h0, 8'h00, 8'h00, 8'h00);
        repeat (20)
            eval_cycle(LINK_GOOD);

        // Open the table without a link reset: the long run already meets
        // the threshold and steps up on the next success.
        wait_drained();
        write_reg(REG_RATE_COUNT, 32'd16);
        repeat (5)
            eval_cycle(LINK_GOOD);
        run_mixed(40);

        // Saturate the frame counter, then evaluate.
        apply_setup(3'd4, 8'd1, 8'd15, 16'd0, 1'b0, 5'd12);
        send_item(FUNC_RESET, 4'h0, 8'h00, 8'h00, 8'h00);
        calm = 1'b1;
        repeat (260)
            send_item(FUNC_REPORT, 4'h3, 8'h11, 8'hFF, 8'd25);
        send_item(FUNC_TICK, 4'h0, 8'h00, 8'h00, 8'h00);
        send_item(FUNC_CHOOSE, 4'h0, 8'h00, 8'h00, 8'h00);
        calm = 1'b0;
        run_mixed(40);

        // largest interval, zero chains, HT scan over five entries
        apply_setup(3'd0, 8'd1, 8'd15, 16'd65535, 1'b1, 5'd5);
        send_item(FUNC_RESET, 4'h0, 8'h00, 8'h00, 8'h00);
        run_mixed(60);

        // wide doubling range on a legacy link
        apply_setup(3'd4, 8'd1, 8'd255, 16'd4, 1'b0, 5'd16);
        send_item(FUNC_RESET, 4'h0, 8'h00, 8'h00, 8'h00);
        run_mixed(60);

        wait_drained();
        $display("summary: %0d item beats, %0d result beats checked, %0d evaluations",
                 items_sent, tracker.results_seen, tracker.evals_seen);
        $display("summary: %0d rate moves across the register setups, %0d mismatches",
                 tracker.moves_seen, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/amrr_pkg.sv
hw/rtl/amrr_ram.sv
hw/rtl/amrr_rate_control.sv
bench/amrr_rate_control_tb.sv
